// ===== rtl/delimited_record_field_splitter_macros.svh =====
// Assertion helpers; each expects clk and arst_n in scope.
`ifndef DELIMITED_RECORD_FIELD_SPLITTER_MACROS_SVH
`define DELIMITED_RECORD_FIELD_SPLITTER_MACROS_SVH

`ifndef SYNTHESIS

`define DRFS_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

`define DRFS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`else

`define DRFS_ASSERT_SAME(lbl, ante, cons)

`define DRFS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/drfs_pkg.sv =====
package drfs_pkg;

	localparam int unsigned ByteW   = 8;
	localparam int unsigned ModeW   = 2;
	localparam int unsigned OutDataW = 16;

	localparam logic [ModeW-1:0] MODE_COMMA   = 2'd0;
	localparam logic [ModeW-1:0] MODE_SEMI    = 2'd1;
	localparam logic [ModeW-1:0] MODE_TAB     = 2'd2;
	localparam logic [ModeW-1:0] MODE_TAB_RAW = 2'd3;

	localparam logic [ModeW-1:0] MODE_RESET = MODE_COMMA;

	localparam logic [ByteW-1:0] CH_COMMA  = 8'h2C;
	localparam logic [ByteW-1:0] CH_SEMI   = 8'h3B;
	localparam logic [ByteW-1:0] CH_TAB    = 8'h09;
	localparam logic [ByteW-1:0] CH_DQUOTE = 8'h22;
	localparam logic [ByteW-1:0] CH_SQUOTE = 8'h27;
	localparam logic [ByteW-1:0] CH_SPACE  = 8'h20;

	function automatic logic [ByteW-1:0] sep_of(input logic [ModeW-1:0] mode);
		logic [ByteW-1:0] sep;
		unique case (mode)
			MODE_COMMA: sep = CH_COMMA;
			MODE_SEMI:  sep = CH_SEMI;
			default:    sep = CH_TAB;
		endcase
		return sep;
	endfunction

endpackage

// ===== rtl/delimited_record_field_splitter.sv =====
// Channel   | Direction | tdata                          | tuser     | tlast
// ----------+-----------+--------------------------------+-----------+-----------
// s_axis    | in        | [7:0] data_byte                | -         | last_byte
// m_axis    | out       | [7:0] field_byte, [8] field_end| has_byte  | record_end
// cfg       | in        | record_mode (2 bits), written while record_mode_wen is high
//
// One byte per cycle while m_axis is not stalled; a byte's result passes from the input register
// to the result register before it is on m_axis, and the parse step between the two registers
// is a single state-machine transition.
// Bytes that give no result (skipped spaces, quotes, dropped bytes) leave no gap upstream.
// arst_n clears the parse state, the mode register and both valid flags.
// A stall on m_axis holds the result register and backs up into the input register.
`include "delimited_record_field_splitter_macros.svh"

module delimited_record_field_splitter #(
	parameter int unsigned OUT_DATA_W = drfs_pkg::OutDataW
) (
	input  logic                         clk,
	input  logic                         arst_n,

	input  logic                         record_mode_wen,
	input  logic [drfs_pkg::ModeW-1:0]   record_mode,

	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [drfs_pkg::ByteW-1:0]   s_axis_tdata,   // [7:0] data_byte
	input  logic                         s_axis_tlast,   // last_byte

	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [OUT_DATA_W-1:0]        m_axis_tdata,   // [7:0] field_byte, [8] field_end
	output logic                         m_axis_tuser,   // has_byte
	output logic                         m_axis_tlast    // record_end
);

	typedef enum logic [2:0] {
		PH_START    = 3'd0,
		PH_PLAIN    = 3'd1,
		PH_QUOTED_E = 3'd2,
		PH_QUOTED_D = 3'd3,
		PH_QSEEN_E  = 3'd4,
		PH_QSEEN_D  = 3'd5,
		PH_SKIP_E   = 3'd6,
		PH_SKIP_D   = 3'd7
	} phase_t;

	phase_t                        phase_q, nxt_phase;
	logic                          dq_q, nxt_dq;
	logic [drfs_pkg::ModeW-1:0]    mode_q;

	logic                          valid_s1, last_s1;
	logic [drfs_pkg::ByteW-1:0]    byte_s1;

	logic                          m_valid_q, has_q, fend_q, rend_q;
	logic [drfs_pkg::ByteW-1:0]    out_byte_q;

	logic                          out_free, adv_s1;
	logic [drfs_pkg::ByteW-1:0]    sep, hq, ch;
	logic                          quoting, emit, fend, fend_fin, has_result;

	assign out_free      = !m_valid_q || m_axis_tready;
	assign adv_s1        = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	assign sep     = drfs_pkg::sep_of(mode_q);
	assign quoting = (mode_q != drfs_pkg::MODE_TAB_RAW);
	assign hq      = dq_q ? drfs_pkg::CH_DQUOTE : drfs_pkg::CH_SQUOTE;

	always_comb begin
		nxt_phase = phase_q;
		nxt_dq    = dq_q;
		emit      = 1'b0;
		fend      = 1'b0;
		ch        = '0;
		unique case (phase_q)
			PH_START: begin
				priority if (quoting && byte_s1 == drfs_pkg::CH_SPACE) begin
					nxt_phase = PH_START;
				end else if (quoting && (byte_s1 == drfs_pkg::CH_DQUOTE ||
				                         byte_s1 == drfs_pkg::CH_SQUOTE)) begin
					nxt_dq    = (byte_s1 == drfs_pkg::CH_DQUOTE);
					nxt_phase = PH_QUOTED_E;
				end else if (byte_s1 == sep) begin
					fend      = 1'b1;
					nxt_phase = PH_START;
				end else begin
					emit      = 1'b1;
					ch        = byte_s1;
					nxt_phase = PH_PLAIN;
				end
			end
			PH_PLAIN: begin
				if (byte_s1 == sep) begin
					fend      = 1'b1;
					nxt_phase = PH_START;
				end else begin
					emit = 1'b1;
					ch   = byte_s1;
				end
			end
			PH_QUOTED_E, PH_QUOTED_D: begin
				if (byte_s1 == hq) begin
					nxt_phase = (phase_q == PH_QUOTED_D) ? PH_QSEEN_D : PH_QSEEN_E;
				end else begin
					emit      = 1'b1;
					ch        = byte_s1;
					nxt_phase = PH_QUOTED_D;
				end
			end
			PH_QSEEN_E, PH_QSEEN_D: begin
				priority if (byte_s1 == hq) begin
					emit      = 1'b1;
					ch        = byte_s1;
					nxt_phase = PH_QUOTED_D;
				end else if (byte_s1 == sep) begin
					fend      = 1'b1;
					nxt_phase = PH_START;
				end else begin
					nxt_phase = (phase_q == PH_QSEEN_D) ? PH_SKIP_D : PH_SKIP_E;
				end
			end
			PH_SKIP_E, PH_SKIP_D: begin
				if (byte_s1 == sep) begin
					fend      = 1'b1;
					nxt_phase = PH_START;
				end
			end
			default: begin
				nxt_phase = PH_START;
			end
		endcase
		fend_fin = fend;
		if (last_s1) begin
			fend_fin  = fend || nxt_phase[0];
			nxt_phase = PH_START;
		end
	end

	assign has_result = emit || fend_fin || last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= drfs_pkg::MODE_RESET;
			phase_q   <= PH_START;
			dq_q      <= 1'b0;
			valid_s1  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (record_mode_wen) begin
				mode_q <= record_mode;
			end
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (adv_s1) begin
				phase_q   <= nxt_phase;
				dq_q      <= nxt_dq;
				m_valid_q <= has_result;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
		if (adv_s1 && has_result) begin
			has_q      <= emit;
			out_byte_q <= ch;
			fend_q     <= fend_fin;
			rend_q     <= last_s1;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = has_q;
	assign m_axis_tlast  = rend_q;
	assign m_axis_tdata  = {{(OUT_DATA_W-drfs_pkg::ByteW-1){1'b0}}, fend_q, out_byte_q};

	`DRFS_ASSERT_SAME(a_no_empty_result, m_valid_q && !has_q, fend_q || rend_q)
	`DRFS_ASSERT_SAME(a_idle_byte_zero, m_valid_q && !has_q, out_byte_q == '0)
	`DRFS_ASSERT_NEXT(a_last_restarts, adv_s1 && last_s1, phase_q == PH_START && m_valid_q)
	`DRFS_ASSERT_NEXT(a_raw_no_quote,
		adv_s1 && mode_q == drfs_pkg::MODE_TAB_RAW && phase_q == PH_START,
		phase_q == PH_START || phase_q == PH_PLAIN)

endmodule
